### src/two_level_round_robin_ready_queue_macros.svh
// Assertion macros used by the ready queue top level.
`ifndef TWO_LEVEL_ROUND_ROBIN_READY_QUEUE_MACROS_SVH
`define TWO_LEVEL_ROUND_ROBIN_READY_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on clk, idle during reset
`define TLRRQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, idle during reset
`define TLRRQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/tlrrq_pkg.sv
// Shared types and constants of the two-level ready queue.
package tlrrq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int ID_BITS     = 16;
	localparam int OP_BITS     = 3;

	// stream word widths, rounded up to whole bytes
	localparam int IN_W     = ((ID_BITS + 7) / 8) * 8;
	localparam int RES_BITS = 2 * ID_BITS + 6;
	localparam int OUT_W    = ((RES_BITS + 7) / 8) * 8;

	typedef enum logic [OP_BITS-1:0] {
		OP_ENQ_COMMON = 3'd0,
		OP_ENQ_RT     = 3'd1,
		OP_ROT_COMMON = 3'd2,
		OP_ROT_RT     = 3'd3,
		OP_REM_COMMON = 3'd4,
		OP_REM_RT     = 3'd5
	} op_t;

	// per-cycle command to every cell of one queue
	typedef struct packed {
		logic push;
		logic pop;
		logic rotate;
	} cell_ctl_t;

	// result word, last field in the lowest bits
	typedef struct packed {
		logic               error;
		logic               realtime_empty;
		logic               common_empty;
		logic               running_is_realtime;
		logic [ID_BITS-1:0] running_id;
		logic               running_valid;
		logic [ID_BITS-1:0] removed_id;
		logic               removed_valid;
	} result_t;

endpackage

### src/two_level_round_robin_ready_queue.sv
// The result word is registered and appears on m_tdata in the cycle after the operation word is taken.
// Throughput: one operation per cycle while m_tready is high; all cells of a queue shift at once.
// s_tready is high whenever the result register is empty or being read.
// Reset (arst_n low) empties both queues by clearing the cell flags and drops m_tvalid;
// stored ids are not cleared and are only read once written.
// Top level of the two-level real-time / common ready queue.
module two_level_round_robin_ready_queue (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [tlrrq_pkg::IN_W-1:0]    s_tdata,  // process_id
	input  logic [tlrrq_pkg::OP_BITS-1:0] s_tuser,  // operation
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// removed_valid, removed_id, running_valid, running_id, running_is_realtime,
	// common_empty, realtime_empty, error, zero fill
	output logic [tlrrq_pkg::OUT_W-1:0]   m_tdata
);

	logic                          accept;
	tlrrq_pkg::op_t                op;
	logic [tlrrq_pkg::ID_BITS-1:0] pid;
	tlrrq_pkg::cell_ctl_t          c_ctl, r_ctl;
	logic [tlrrq_pkg::ID_BITS-1:0] c_head, c_head_nxt, r_head, r_head_nxt;
	logic                          c_empty, c_empty_nxt, c_full, c_several;
	logic                          r_empty, r_empty_nxt, r_full, r_several;
	logic                          c_pop, r_pop, err;
	tlrrq_pkg::result_t            res;
	logic                          m_tvalid_q;
	logic [tlrrq_pkg::OUT_W-1:0]   m_tdata_q;
	tlrrq_pkg::result_t            out_res;

	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign op       = tlrrq_pkg::op_t'(s_tuser);
	assign pid      = s_tdata[tlrrq_pkg::ID_BITS-1:0];

	// decode the operation into cell commands
	always_comb begin
		c_ctl = '0;
		r_ctl = '0;
		c_pop = 1'b0;
		r_pop = 1'b0;
		err   = 1'b0;
		case (op)
			tlrrq_pkg::OP_ENQ_COMMON: begin
				c_ctl.push = !c_full;
				err        = c_full;
			end
			tlrrq_pkg::OP_ENQ_RT: begin
				r_ctl.push = !r_full;
				err        = r_full;
			end
			tlrrq_pkg::OP_ROT_COMMON: begin
				// a single entry rotates onto itself, so only shift with two or more
				c_ctl.rotate = c_several;
				err          = c_empty;
			end
			tlrrq_pkg::OP_ROT_RT: begin
				r_ctl.rotate = r_several;
			end
			tlrrq_pkg::OP_REM_COMMON: begin
				c_pop = !c_empty;
			end
			tlrrq_pkg::OP_REM_RT: begin
				// fall through to the common queue when real-time is empty
				r_pop = !r_empty;
				c_pop = r_empty && !c_empty;
			end
			default: begin
			end
		endcase
		c_ctl.pop = c_pop;
		r_ctl.pop = r_pop;
		// apply nothing unless a word is taken
		if (!accept) begin
			c_ctl = '0;
			r_ctl = '0;
		end
	end

	tlrrq_queue u_common (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (c_ctl),
		.push_id   (pid),
		.head_id   (c_head),
		.head_nxt  (c_head_nxt),
		.empty     (c_empty),
		.empty_nxt (c_empty_nxt),
		.full      (c_full),
		.several   (c_several)
	);

	tlrrq_queue u_realtime (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (r_ctl),
		.push_id   (pid),
		.head_id   (r_head),
		.head_nxt  (r_head_nxt),
		.empty     (r_empty),
		.empty_nxt (r_empty_nxt),
		.full      (r_full),
		.several   (r_several)
	);

	// build the result: removed id from the current head, the rest from the post-operation queue state
	always_comb begin
		res                     = '0;
		res.removed_valid       = c_pop || r_pop;
		res.removed_id          = r_pop ? r_head : (c_pop ? c_head : '0);
		res.running_valid       = !r_empty_nxt || !c_empty_nxt;
		res.running_is_realtime = !r_empty_nxt;
		res.running_id          = !r_empty_nxt ? r_head_nxt :
		                          (!c_empty_nxt ? c_head_nxt : '0);
		res.common_empty        = c_empty_nxt;
		res.realtime_empty      = r_empty_nxt;
		res.error               = err;
	end

	// hold the result word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s_tready) begin
			m_tvalid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_tdata_q <= tlrrq_pkg::OUT_W'(res);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign out_res  = tlrrq_pkg::result_t'(m_tdata_q[tlrrq_pkg::RES_BITS-1:0]);

`include "two_level_round_robin_ready_queue_macros.svh"

	`TLRRQ_ASSERT_NEXT(a_accept_gives_word, accept, m_tvalid_q, "taken word gave no result")
	`TLRRQ_ASSERT_NEXT(a_error_keeps_fill, accept && err, $stable(c_empty) && $stable(r_empty), "rejected operation changed a queue")
	`TLRRQ_ASSERT_NOW(a_realtime_first, m_tvalid_q && !out_res.realtime_empty, out_res.running_is_realtime && out_res.running_valid, "common id running while real-time work waits")

endmodule

### src/tlrrq_cell.sv
// One slot of a shifting queue: holds an id and its occupied flag.
module tlrrq_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tlrrq_pkg::cell_ctl_t          ctl,
	input  logic [tlrrq_pkg::ID_BITS-1:0] push_id,
	input  logic [tlrrq_pkg::ID_BITS-1:0] head_id,
	input  logic                          prev_valid,
	input  logic                          next_valid,
	input  logic [tlrrq_pkg::ID_BITS-1:0] next_id,
	output logic                          valid_q,
	output logic [tlrrq_pkg::ID_BITS-1:0] id_q,
	output logic                          valid_nxt,
	output logic [tlrrq_pkg::ID_BITS-1:0] id_nxt
);

	// pick the next slot contents from the command and the neighbours
	always_comb begin
		valid_nxt = valid_q;
		id_nxt    = id_q;
		if (ctl.pop) begin
			valid_nxt = next_valid;
			id_nxt    = next_id;
		end else if (ctl.rotate) begin
			// the last occupied slot takes the old head, the rest advance
			id_nxt = (valid_q && !next_valid) ? head_id : next_id;
		end else if (ctl.push && !valid_q && prev_valid) begin
			valid_nxt = 1'b1;
			id_nxt    = push_id;
		end
	end

	// hold the occupied flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_nxt;
		end
	end

	// hold the id
	always_ff @(posedge clk) begin
		id_q <= id_nxt;
	end

endmodule

### src/tlrrq_queue.sv
// FIFO built from a row of cells, head in the first cell.
module tlrrq_queue (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tlrrq_pkg::cell_ctl_t          ctl,
	input  logic [tlrrq_pkg::ID_BITS-1:0] push_id,
	output logic [tlrrq_pkg::ID_BITS-1:0] head_id,
	output logic [tlrrq_pkg::ID_BITS-1:0] head_nxt,
	output logic                          empty,
	output logic                          empty_nxt,
	output logic                          full,
	output logic                          several
);

	localparam int D = tlrrq_pkg::QUEUE_DEPTH;

	logic                          valid_c [D];
	logic [tlrrq_pkg::ID_BITS-1:0] id_c    [D];
	logic                          vnxt_c  [D];
	logic [tlrrq_pkg::ID_BITS-1:0] inxt_c  [D];

	// chain the cells: each looks at its neighbours and at the head cell
	for (genvar i = 0; i < D; i++) begin : g_cell
		logic                          prev_v;
		logic                          next_v;
		logic [tlrrq_pkg::ID_BITS-1:0] next_d;

		if (i == 0) begin : g_first
			assign prev_v = 1'b1;
		end else begin : g_mid
			assign prev_v = valid_c[i-1];
		end

		if (i == D - 1) begin : g_last
			assign next_v = 1'b0;
			assign next_d = '0;
		end else begin : g_inner
			assign next_v = valid_c[i+1];
			assign next_d = id_c[i+1];
		end

		tlrrq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.push_id    (push_id),
			.head_id    (id_c[0]),
			.prev_valid (prev_v),
			.next_valid (next_v),
			.next_id    (next_d),
			.valid_q    (valid_c[i]),
			.id_q       (id_c[i]),
			.valid_nxt  (vnxt_c[i]),
			.id_nxt     (inxt_c[i])
		);
	end

	// report head and fill state
	assign head_id   = id_c[0];
	assign head_nxt  = inxt_c[0];
	assign empty     = !valid_c[0];
	assign empty_nxt = !vnxt_c[0];
	assign full      = valid_c[D-1];
	assign several   = valid_c[1];

endmodule

### test/two_level_round_robin_ready_queue_test.sv
// Self-checking stream testbench for the two-level round-robin ready queue.
`timescale 1ns / 1ps

module two_level_round_robin_ready_queue_test;
	import tlrrq_pkg::*;

	localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
	localparam int CNT_BITS = PTR_BITS + 1;

	// operation codes the package leaves unnamed; the block must ignore them
	localparam logic [OP_BITS-1:0] OP_SPARE_SIX   = 3'd6;
	localparam logic [OP_BITS-1:0] OP_SPARE_SEVEN = 3'd7;

	// queue indexes inside the tracker
	localparam int Q_COMMON = 0;
	localparam int Q_RT     = 1;

	// random phases, each biased towards one kind of traffic
	localparam int PH_FILL   = 0;
	localparam int PH_DRAIN  = 1;
	localparam int PH_ROTATE = 2;
	localparam int PH_MIXED  = 3;

	localparam int RANDOM_ITEMS    = 1500;
	localparam int PHASE_ITEMS     = 100;
	localparam int HOLD_OFF_AT     = 700;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int SETTLE_CYCLES   = 4;
	localparam int CYCLE_LIMIT     = 600000;
	localparam int REPORT_LIMIT    = 10;
	localparam int RING_DEPTH      = 2048;

	// tracks both queues and the result words they must produce
	class ready_queue_tracker;
		logic [ID_BITS-1:0]  ids [2][QUEUE_DEPTH];
		logic [PTR_BITS-1:0] head [2];
		logic [CNT_BITS-1:0] fill [2];
		result_t             expected_ring [RING_DEPTH];
		int wr_count, rd_count;
		int mismatches, checked, flagged_errors, fallthroughs;
		int peak [2];

		function new();
			foreach (head[q]) begin
				head[q] = '0;
				fill[q] = '0;
				peak[q] = 0;
			end
			wr_count = 0;
			rd_count = 0;
			mismatches = 0;
			checked = 0;
			flagged_errors = 0;
			fallthroughs = 0;
		endfunction

		function int outstanding();
			return wr_count - rd_count;
		endfunction

		function void note_expected(result_t r);
			expected_ring[wr_count % RING_DEPTH] = r;
			wr_count++;
		endfunction

		function result_t take_expected();
			result_t r;
			r = expected_ring[rd_count % RING_DEPTH];
			rd_count++;
			return r;
		endfunction

		function bit push_id(int q, logic [ID_BITS-1:0] id);
			logic [PTR_BITS-1:0] slot;
			if (fill[q] == QUEUE_DEPTH)
				return 1'b0;
			slot = head[q] + fill[q][PTR_BITS-1:0];
			ids[q][slot] = id;
			fill[q]++;
			if (int'(fill[q]) > peak[q])
				peak[q] = int'(fill[q]);
			return 1'b1;
		endfunction

		function logic [ID_BITS-1:0] pop_id(int q);
			logic [ID_BITS-1:0] id;
			id = ids[q][head[q]];
			head[q]++;
			fill[q]--;
			return id;
		endfunction

		// advance the queues by one accepted operation word
		function void apply_op(logic [OP_BITS-1:0] op, logic [ID_BITS-1:0] id);
			result_t r;
			logic [ID_BITS-1:0] rotated;
			r = '0;
			case (op)
				OP_ENQ_COMMON: r.error = !push_id(Q_COMMON, id);
				OP_ENQ_RT:     r.error = !push_id(Q_RT, id);
				OP_ROT_COMMON: begin
					if (fill[Q_COMMON] == 0) begin
						r.error = 1'b1;
					end else begin
						rotated = pop_id(Q_COMMON);
						void'(push_id(Q_COMMON, rotated));
					end
				end
				OP_ROT_RT: begin
					if (fill[Q_RT] > 1) begin
						rotated = pop_id(Q_RT);
						void'(push_id(Q_RT, rotated));
					end
				end
				OP_REM_COMMON: begin
					if (fill[Q_COMMON] != 0) begin
						r.removed_valid = 1'b1;
						r.removed_id = pop_id(Q_COMMON);
					end
				end
				OP_REM_RT: begin
					// an empty real-time queue hands the remove on to the common one
					if (fill[Q_RT] != 0) begin
						r.removed_valid = 1'b1;
						r.removed_id = pop_id(Q_RT);
					end else if (fill[Q_COMMON] != 0) begin
						r.removed_valid = 1'b1;
						r.removed_id = pop_id(Q_COMMON);
						fallthroughs++;
					end
				end
				default: ;
			endcase

			// real-time head runs whenever there is one
			if (fill[Q_RT] != 0) begin
				r.running_valid = 1'b1;
				r.running_is_realtime = 1'b1;
				r.running_id = ids[Q_RT][head[Q_RT]];
			end else if (fill[Q_COMMON] != 0) begin
				r.running_valid = 1'b1;
				r.running_id = ids[Q_COMMON][head[Q_COMMON]];
			end
			r.common_empty = (fill[Q_COMMON] == 0);
			r.realtime_empty = (fill[Q_RT] == 0);
			if (r.error)
				flagged_errors++;
			note_expected(r);
		endfunction

		function void note_mismatch(string msg);
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("mismatch: %s", msg);
		endfunction

		function void compare_field(string name, logic [ID_BITS-1:0] want,
				logic [ID_BITS-1:0] got);
			if (got !== want)
				note_mismatch($sformatf("result %0d %s: expected %h, got %h",
					checked, name, want, got));
		endfunction

		// compare one result word with the oldest expectation
		function void check_word(logic [OUT_W-1:0] word);
			result_t got, want;
			got = result_t'(word[RES_BITS-1:0]);
			checked++;
			if (outstanding() == 0) begin
				note_mismatch($sformatf("result %0d arrived with nothing expected: %h",
					checked, word));
				return;
			end
			want = take_expected();
			compare_field("removed_valid", ID_BITS'(want.removed_valid),
				ID_BITS'(got.removed_valid));
			compare_field("removed_id", want.removed_id, got.removed_id);
			compare_field("running_valid", ID_BITS'(want.running_valid),
				ID_BITS'(got.running_valid));
			compare_field("running_id", want.running_id, got.running_id);
			compare_field("running_is_realtime", ID_BITS'(want.running_is_realtime),
				ID_BITS'(got.running_is_realtime));
			compare_field("common_empty", ID_BITS'(want.common_empty),
				ID_BITS'(got.common_empty));
			compare_field("realtime_empty", ID_BITS'(want.realtime_empty),
				ID_BITS'(got.realtime_empty));
			compare_field("error", ID_BITS'(want.error), ID_BITS'(got.error));
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [IN_W-1:0]    s_tdata;  // process_id
	logic [OP_BITS-1:0] s_tuser;  // operation
	logic               m_tvalid;
	logic               m_tready;
	// removed_valid, removed_id, running_valid, running_id, running_is_realtime,
	// common_empty, realtime_empty, error, zero fill
	logic [OUT_W-1:0]   m_tdata;

	ready_queue_tracker tracker;
	int items_sent = 0;
	int directed_items = 0;
	int cycles = 0;
	bit held_off = 1'b0;

	two_level_round_robin_ready_queue dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #6 clk = ~clk;

	// bound the run
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("two_level_round_robin_ready_queue_test failed");
			$finish;
		end
	end

	// check every result word taken from the block
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.check_word(m_tdata);
	end

	// offer one operation word, hold it until taken, then idle for the given gap
	task automatic send_op(input logic [OP_BITS-1:0] op, input logic [ID_BITS-1:0] id,
			input int gap);
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= IN_W'(id);
		do @(posedge clk); while (!s_tready);
		tracker.apply_op(op, id);
		items_sent++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [OP_BITS-1:0] pick_op(int phase);
		int r;
		r = $urandom_range(0, 99);
		case (phase)
			PH_FILL: begin
				if (r < 40) return OP_ENQ_COMMON;
				if (r < 80) return OP_ENQ_RT;
				if (r < 88) return OP_ROT_COMMON;
				if (r < 94) return OP_ROT_RT;
				return OP_REM_RT;
			end
			PH_DRAIN: begin
				if (r < 15) return OP_ENQ_COMMON;
				if (r < 25) return OP_ENQ_RT;
				if (r < 30) return OP_ROT_COMMON;
				if (r < 35) return OP_ROT_RT;
				if (r < 65) return OP_REM_COMMON;
				return OP_REM_RT;
			end
			PH_ROTATE: begin
				if (r < 15) return OP_ENQ_COMMON;
				if (r < 30) return OP_ENQ_RT;
				if (r < 60) return OP_ROT_COMMON;
				if (r < 85) return OP_ROT_RT;
				if (r < 93) return OP_REM_COMMON;
				return OP_REM_RT;
			end
			default: begin
				if (r < 4)
					return $urandom_range(0, 1) ? OP_SPARE_SIX : OP_SPARE_SEVEN;
				return OP_BITS'($urandom_range(OP_ENQ_COMMON, OP_REM_RT));
			end
		endcase
	endfunction

	function automatic logic [ID_BITS-1:0] pick_id();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return '0;
		if (r < 10)
			return '1;
		return ID_BITS'($urandom_range(0, (1 << ID_BITS) - 1));
	endfunction

	// mostly back to back, some short gaps, a few long ones; none at all when quiet
	function automatic int pick_gap(bit quiet);
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// empty queues, ignored codes, extreme ids, single-entry rotation, fall-through
	task automatic run_directed();
		send_op(OP_REM_COMMON, 16'h1234, 0);
		send_op(OP_REM_RT, 16'h4321, 0);
		send_op(OP_ROT_COMMON, 16'hFFFF, 0);
		send_op(OP_ROT_RT, 16'h0000, 0);
		send_op(OP_SPARE_SIX, 16'hFFFF, 0);
		send_op(OP_SPARE_SEVEN, 16'h0000, 1);
		send_op(OP_ENQ_COMMON, 16'h0000, 0);
		send_op(OP_ENQ_COMMON, 16'hFFFF, 0);
		send_op(OP_ROT_COMMON, 16'h0000, 0);
		send_op(OP_ENQ_RT, 16'hA5A5, 2);
		send_op(OP_ROT_RT, 16'h0000, 0);
		send_op(OP_ENQ_RT, 16'h5A5A, 0);
		send_op(OP_ROT_RT, 16'h0000, 0);
		send_op(OP_SPARE_SIX, 16'h0000, 0);
		send_op(OP_SPARE_SEVEN, 16'hFFFF, 0);
		send_op(OP_REM_RT, 16'h0000, 0);
		send_op(OP_REM_RT, 16'h0000, 3);
		send_op(OP_REM_RT, 16'h0000, 0);
		send_op(OP_REM_COMMON, 16'h0000, 0);
		send_op(OP_REM_COMMON, 16'h0000, 0);
	endtask

	// result side: random ready and stall stretches, plus one long hold-off
	initial begin
		int stretch;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!held_off && items_sent >= HOLD_OFF_AT) begin
				held_off = 1'b1;
				m_tready <= 1'b0;
				stretch = HOLD_OFF_CYCLES;
			end else if ($urandom_range(0, 99) < 60) begin
				m_tready <= 1'b1;
				stretch = $urandom_range(1, 40);
			end else begin
				m_tready <= 1'b0;
				stretch = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
					: $urandom_range(1, 3);
			end
			repeat (stretch) @(posedge clk);
		end
	end

	// operation side and end of run
	initial begin
		int phase;
		bit quiet;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= '0;
		tracker = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		directed_items = items_sent;

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			phase = (i / PHASE_ITEMS) % 4;
			quiet = ((i / PHASE_ITEMS) % 5) == 3;
			send_op(pick_op(phase), pick_id(), pick_gap(quiet));
		end
		s_tvalid <= 1'b0;

		// drain outstanding results, then watch for strays
		while (tracker.outstanding() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d operations (%0d directed), checked %0d results, %0d mismatches.",
			items_sent, directed_items, tracker.checked, tracker.mismatches);
		$display("Error flag %0d times, %0d real-time removes fell through; peak depth %0d/%0d.",
			tracker.flagged_errors, tracker.fallthroughs, tracker.peak[Q_COMMON],
			tracker.peak[Q_RT]);
		if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
			$display("two_level_round_robin_ready_queue_test passed");
		end else begin
			$display("two_level_round_robin_ready_queue_test failed");
		end
		$finish;
	end

endmodule
